@@ hw/rtl/bfld_pkg.sv @@
// ----------------------------------------------------------------------------
// bfld_pkg - shared types and constants
// Constants, parse phase codes and the history command struct used by the
// block-framed LZSS decoder modules.
// ----------------------------------------------------------------------------
package bfld_pkg;

    // History memory geometry
    localparam int HIST_DEPTH = 4096;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int FILL_W     = HIST_AW + 1;

    // Copy lengths: 4-bit length field, plus the shortest copy
    localparam int COPY_MAX   = 18;
    localparam int COPY_LEN_W = $clog2(COPY_MAX + 1);
    localparam logic [COPY_LEN_W-1:0] COPY_LEN_MIN = COPY_LEN_W'(COPY_MAX - 15);

    // Writing starts this far below the top of the history
    localparam logic [HIST_AW-1:0] HIST_START = HIST_AW'(HIST_DEPTH - COPY_MAX);
    localparam logic [7:0]         HIST_BLANK = 8'h20;

    // Flag byte holds eight item flags
    localparam logic [3:0] FLAGS_PER_BYTE = 4'd8;

    // Parse phase codes
    localparam logic [2:0] PH_CNT_HI = 3'd0;
    localparam logic [2:0] PH_CNT_LO = 3'd1;
    localparam logic [2:0] PH_STORED = 3'd2;
    localparam logic [2:0] PH_FLAG   = 3'd3;
    localparam logic [2:0] PH_ITEM   = 3'd4;
    localparam logic [2:0] PH_LEN    = 3'd5;

    // Result kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Command from the parser to the history unit
    typedef struct packed {
        logic               clear;
        logic               rd_en;
        logic [HIST_AW-1:0] rd_addr;
        logic               wr_en;
        logic [7:0]         wr_data;
    } hist_cmd_t;

endpackage

@@ hw/rtl/bfld_ifs.sv @@
// ----------------------------------------------------------------------------
// bfld_ifs - channel interfaces
// Valid/ready channels for compressed input, decoded output and the
// configuration write.
// ----------------------------------------------------------------------------

// Compressed byte channel
interface bfld_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// Decoded byte channel
interface bfld_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       kind;
    logic       run_last;

    modport source (output valid, output out_byte, output kind, output run_last,
                    input ready);
    modport sink   (input valid, input out_byte, input kind, input run_last,
                    output ready);
endinterface

// Configuration write channel
interface bfld_cfg_if;
    logic valid;
    logic ready;
    logic stored_mode;

    modport source (output valid, output stored_mode, input ready);
    modport sink   (input valid, input stored_mode, output ready);
endinterface

@@ hw/rtl/bfld_ram.sv @@
// ----------------------------------------------------------------------------
// bfld_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds while idle.
// ----------------------------------------------------------------------------
module bfld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/bfld_hist.sv @@
// ----------------------------------------------------------------------------
// bfld_hist - history window
// 4096-byte history RAM with its write pointer. A fill count marks which
// entries were written since the last clear; others read as spaces.
// ----------------------------------------------------------------------------
module bfld_hist (
    input  logic                clk,
    input  logic                rst_n,
    input  bfld_pkg::hist_cmd_t cmd,
    output logic [7:0]          rd_data
);

    logic [bfld_pkg::HIST_AW-1:0] wr_pos_reg, wr_pos_next;
    logic [bfld_pkg::FILL_W-1:0]  fill_reg, fill_next;
    logic                         rd_ok_reg, rd_ok_next;
    logic [bfld_pkg::HIST_AW-1:0] rd_rel;
    logic [7:0]                   ram_rdata;

    // Distance of the read address from the block's first write
    assign rd_rel = cmd.rd_addr - bfld_pkg::HIST_START;

    always_comb
    begin
        wr_pos_next = wr_pos_reg;
        fill_next   = fill_reg;
        rd_ok_next  = rd_ok_reg;
        if (cmd.clear)
        begin
            wr_pos_next = bfld_pkg::HIST_START;
            fill_next   = '0;
        end
        else if (cmd.wr_en)
        begin
            wr_pos_next = wr_pos_reg + 1'b1;
            if (fill_reg != bfld_pkg::FILL_W'(bfld_pkg::HIST_DEPTH))
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
        if (cmd.rd_en)
        begin
            rd_ok_next = ({1'b0, rd_rel} < fill_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_pos_reg <= bfld_pkg::HIST_START;
            fill_reg   <= '0;
            rd_ok_reg  <= 1'b0;
        end
        else
        begin
            wr_pos_reg <= wr_pos_next;
            fill_reg   <= fill_next;
            rd_ok_reg  <= rd_ok_next;
        end
    end

    bfld_ram #(
        .WIDTH (8),
        .DEPTH (bfld_pkg::HIST_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (wr_pos_reg),
        .wdata (cmd.wr_data),
        .re    (cmd.rd_en),
        .raddr (cmd.rd_addr),
        .rdata (ram_rdata)
    );

    // Unwritten entries read as blanks
    assign rd_data = rd_ok_reg ? ram_rdata : bfld_pkg::HIST_BLANK;

    // Fill count never passes the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= bfld_pkg::FILL_W'(bfld_pkg::HIST_DEPTH))
        else $error("history fill count overflow");

    // A clear restarts the window
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (fill_reg == '0) && (wr_pos_reg == bfld_pkg::HIST_START))
        else $error("history clear not applied");

    // Write pointer advances by one per write
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_en && !cmd.clear) |=> wr_pos_reg == $past(wr_pos_reg) + 1'b1)
        else $error("history write pointer skipped");

endmodule

@@ hw/rtl/bfld_ctrl.sv @@
// ----------------------------------------------------------------------------
// bfld_ctrl - stream parser and copy sequencer
// Parses block headers, flags, literals and copy items, drives the history
// unit and holds the output register.
// ----------------------------------------------------------------------------
module bfld_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    bfld_in_if.sink             src,
    bfld_out_if.source          dst,
    bfld_cfg_if.sink            cfg,
    output bfld_pkg::hist_cmd_t hcmd,
    input  logic [7:0]          h_rdata
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CRD  = 3'b010,
        S_CWR  = 3'b100
    } ctl_state_t;

    ctl_state_t st_reg, st_next;

    logic                            stored_mode_reg;
    logic [2:0]                      phase_reg, phase_next;
    logic [7:0]                      count_high_reg, count_high_next;
    logic [15:0]                     block_left_reg, block_left_next;
    logic [7:0]                      flag_bits_reg, flag_bits_next;
    logic [3:0]                      flag_index_reg, flag_index_next;
    logic [7:0]                      offset_low_reg, offset_low_next;
    logic                            finished_reg, finished_next;
    logic [bfld_pkg::HIST_AW-1:0]    cp_rd_reg, cp_rd_next;
    logic [bfld_pkg::COPY_LEN_W-1:0] cp_left_reg, cp_left_next;

    logic       out_v_reg, out_v_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       kind_reg, kind_next;
    logic       run_last_reg, run_last_next;

    logic        out_free;
    logic        accept;
    logic        load_out;
    logic [15:0] count_v;
    logic [15:0] left_dec;
    logic [3:0]  index_inc;
    logic        copy_end;

    // Handshakes
    assign out_free  = !out_v_reg || dst.ready;
    assign src.ready = (st_reg == S_IDLE) && out_free;
    assign accept    = src.valid && src.ready;
    assign cfg.ready = 1'b1;

    assign count_v   = {count_high_reg, src.in_byte};
    assign left_dec  = block_left_reg - 16'd1;
    assign index_inc = flag_index_reg + 4'd1;
    assign copy_end  = (cp_left_reg == bfld_pkg::COPY_LEN_W'(1));

    // Parser and copy sequencing
    always_comb
    begin
        st_next         = st_reg;
        phase_next      = phase_reg;
        count_high_next = count_high_reg;
        block_left_next = block_left_reg;
        flag_bits_next  = flag_bits_reg;
        flag_index_next = flag_index_reg;
        offset_low_next = offset_low_reg;
        finished_next   = finished_reg;
        cp_rd_next      = cp_rd_reg;
        cp_left_next    = cp_left_reg;
        hcmd            = '0;
        load_out        = 1'b0;
        out_byte_next   = 8'd0;
        kind_next       = bfld_pkg::KIND_DATA;
        run_last_next   = 1'b1;

        case (st_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (stored_mode_reg)
                    begin
                        // Pass-through, parser untouched
                        load_out      = 1'b1;
                        out_byte_next = src.in_byte;
                    end
                    else
                    begin
                        if (!finished_reg)
                        begin
                            case (phase_reg)
                                bfld_pkg::PH_CNT_LO:
                                begin
                                    if (count_v == 16'd0)
                                    begin
                                        // End of stream marker
                                        load_out      = 1'b1;
                                        kind_next     = bfld_pkg::KIND_END;
                                        finished_next = 1'b1;
                                        phase_next    = bfld_pkg::PH_CNT_HI;
                                    end
                                    else if (count_v[15])
                                    begin
                                        block_left_next = (~count_v) + 16'd1;
                                        phase_next      = bfld_pkg::PH_STORED;
                                    end
                                    else
                                    begin
                                        block_left_next = count_v;
                                        hcmd.clear      = 1'b1;
                                        phase_next      = bfld_pkg::PH_FLAG;
                                    end
                                end
                                bfld_pkg::PH_STORED:
                                begin
                                    load_out        = 1'b1;
                                    out_byte_next   = src.in_byte;
                                    block_left_next = left_dec;
                                    if (left_dec == 16'd0)
                                    begin
                                        phase_next = bfld_pkg::PH_CNT_HI;
                                    end
                                end
                                bfld_pkg::PH_FLAG:
                                begin
                                    flag_bits_next  = src.in_byte;
                                    flag_index_next = 4'd0;
                                    phase_next      = bfld_pkg::PH_ITEM;
                                    block_left_next = left_dec;
                                    if (left_dec == 16'd0)
                                    begin
                                        phase_next = bfld_pkg::PH_CNT_HI;
                                    end
                                end
                                bfld_pkg::PH_ITEM:
                                begin
                                    block_left_next = left_dec;
                                    if (flag_bits_reg[0])
                                    begin
                                        // Literal
                                        hcmd.wr_en      = 1'b1;
                                        hcmd.wr_data    = src.in_byte;
                                        load_out        = 1'b1;
                                        out_byte_next   = src.in_byte;
                                        flag_bits_next  = flag_bits_reg >> 1;
                                        flag_index_next = index_inc;
                                        if (left_dec == 16'd0)
                                        begin
                                            phase_next = bfld_pkg::PH_CNT_HI;
                                        end
                                        else if (index_inc >= bfld_pkg::FLAGS_PER_BYTE)
                                        begin
                                            phase_next = bfld_pkg::PH_FLAG;
                                        end
                                        else
                                        begin
                                            phase_next = bfld_pkg::PH_ITEM;
                                        end
                                    end
                                    else
                                    begin
                                        offset_low_next = src.in_byte;
                                        phase_next      = bfld_pkg::PH_LEN;
                                        if (left_dec == 16'd0)
                                        begin
                                            phase_next = bfld_pkg::PH_CNT_HI;
                                        end
                                    end
                                end
                                bfld_pkg::PH_LEN:
                                begin
                                    // Launch the copy; parse state moves on now
                                    cp_rd_next      = {src.in_byte[7:4], offset_low_reg};
                                    cp_left_next    = bfld_pkg::COPY_LEN_W'(src.in_byte[3:0])
                                                      + bfld_pkg::COPY_LEN_MIN;
                                    st_next         = S_CRD;
                                    block_left_next = left_dec;
                                    flag_bits_next  = flag_bits_reg >> 1;
                                    flag_index_next = index_inc;
                                    if (left_dec == 16'd0)
                                    begin
                                        phase_next = bfld_pkg::PH_CNT_HI;
                                    end
                                    else if (index_inc >= bfld_pkg::FLAGS_PER_BYTE)
                                    begin
                                        phase_next = bfld_pkg::PH_FLAG;
                                    end
                                    else
                                    begin
                                        phase_next = bfld_pkg::PH_ITEM;
                                    end
                                end
                                default:
                                begin
                                    count_high_next = src.in_byte;
                                    phase_next      = bfld_pkg::PH_CNT_LO;
                                end
                            endcase
                        end
                        // Final byte resynchronizes the parser
                        if (src.in_last)
                        begin
                            phase_next    = bfld_pkg::PH_CNT_HI;
                            finished_next = 1'b0;
                        end
                    end
                end
            end
            S_CRD:
            begin
                hcmd.rd_en   = 1'b1;
                hcmd.rd_addr = cp_rd_reg;
                st_next      = S_CWR;
            end
            S_CWR:
            begin
                if (out_free)
                begin
                    load_out      = 1'b1;
                    out_byte_next = h_rdata;
                    run_last_next = copy_end;
                    hcmd.wr_en    = 1'b1;
                    hcmd.wr_data  = h_rdata;
                    cp_rd_next    = cp_rd_reg + 1'b1;
                    cp_left_next  = cp_left_reg - 1'b1;
                    st_next       = copy_end ? S_IDLE : S_CRD;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    // Output valid
    always_comb
    begin
        out_v_next = out_v_reg;
        if (load_out)
        begin
            out_v_next = 1'b1;
        end
        else if (dst.ready)
        begin
            out_v_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg          <= S_IDLE;
            stored_mode_reg <= 1'b0;
            phase_reg       <= bfld_pkg::PH_CNT_HI;
            count_high_reg  <= '0;
            block_left_reg  <= '0;
            flag_bits_reg   <= '0;
            flag_index_reg  <= '0;
            offset_low_reg  <= '0;
            finished_reg    <= 1'b0;
            cp_rd_reg       <= '0;
            cp_left_reg     <= '0;
            out_v_reg       <= 1'b0;
        end
        else
        begin
            st_reg          <= st_next;
            phase_reg       <= phase_next;
            count_high_reg  <= count_high_next;
            block_left_reg  <= block_left_next;
            flag_bits_reg   <= flag_bits_next;
            flag_index_reg  <= flag_index_next;
            offset_low_reg  <= offset_low_next;
            finished_reg    <= finished_next;
            cp_rd_reg       <= cp_rd_next;
            cp_left_reg     <= cp_left_next;
            out_v_reg       <= out_v_next;
            if (cfg.valid)
            begin
                stored_mode_reg <= cfg.stored_mode;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_byte_reg <= out_byte_next;
            kind_reg     <= kind_next;
            run_last_reg <= run_last_next;
        end
    end

    assign dst.valid    = out_v_reg;
    assign dst.out_byte = out_byte_reg;
    assign dst.kind     = kind_reg;
    assign dst.run_last = run_last_reg;

    // A copy in flight always has bytes left
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_CRD || st_reg == S_CWR) |-> cp_left_reg != '0)
        else $error("copy sequencer running with nothing left");

    // Every read is followed by its write/emit step
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_CRD) |=> (st_reg == S_CWR))
        else $error("copy read not followed by write step");

    // Inside a block the byte budget is never exhausted
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == bfld_pkg::PH_STORED || phase_reg == bfld_pkg::PH_FLAG ||
         phase_reg == bfld_pkg::PH_ITEM || phase_reg == bfld_pkg::PH_LEN)
        |-> block_left_reg != 16'd0)
        else $error("block phase with zero bytes left");

    // Flag index stays within one flag byte
    assert property (@(posedge clk) disable iff (!rst_n)
        flag_index_reg <= bfld_pkg::FLAGS_PER_BYTE)
        else $error("flag index past flag byte");

endmodule

@@ hw/rtl/block_framed_lzss_decoder_core.sv @@
// ----------------------------------------------------------------------------
// block_framed_lzss_decoder_core - block-framed LZSS decoder
// Compressed bytes in through src, decoded bytes out through dst.
// ----------------------------------------------------------------------------
// Usage:
//   src carries one compressed byte per item (in_byte, in_last marks the
//   final byte). dst carries decoded bytes (out_byte), kind marks the end of
//   stream marker, run_last flags the last result caused by an input item.
//   cfg writes stored_mode; set it only while the block is idle.
// Item handling:
//   Header, flag, stored and literal items are handled as they are accepted;
//   a result appears on dst the cycle after acceptance. A copy item (len
//   3..18) then runs its bytes in turn: each copied byte is a history read
//   step followed by a write/emit step through the single history RAM.
//   Input is held off while a copy runs.
// Reset:
//   Parser expects a count header, stored_mode is 0 and the history reads
//   as spaces. No clearing pass: a fill count marks written entries, so a
//   new compressed block does not wait for the RAM to be cleared.
// Stalls:
//   One output register; while dst stalls a pending result holds and new
//   input is taken only once the register can be reloaded.
// ----------------------------------------------------------------------------
module block_framed_lzss_decoder_core (
    input  logic       clk,
    input  logic       rst_n,
    bfld_in_if.sink    src,
    bfld_out_if.source dst,
    bfld_cfg_if.sink   cfg
);

    bfld_pkg::hist_cmd_t hcmd;
    logic [7:0]          h_rdata;

    bfld_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .src     (src),
        .dst     (dst),
        .cfg     (cfg),
        .hcmd    (hcmd),
        .h_rdata (h_rdata)
    );

    bfld_hist u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (hcmd),
        .rd_data (h_rdata)
    );

endmodule
